// ===== rtl/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
`default_nettype none

package rau_pkg;

    // Port widths fixed by the interface
    localparam int RAU_IN_W  = 32;
    localparam int RAU_RES_W = 64;
    localparam int RAU_OP_W  = 3;

    // Default operand width (low bits of each input port that are used)
    localparam int RAU_OPERAND_WIDTH = 32;

    // Status codes
    localparam logic STAT_OK       = 1'b0;
    localparam logic STAT_DEN_ZERO = 1'b1;

    // Operation codes
    typedef enum logic [RAU_OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_RED = 3'd4
    } t_op;

    // Top-level sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_RED_GO,
        S_RED_WAIT,
        S_OUT
    } t_state;

    // GCD / divide unit states
    typedef enum logic [1:0] {
        G_IDLE,
        G_SHIFT,
        G_LOOP,
        G_DIV
    } t_gcd_state;

    // Status from the GCD unit back to the sequencer
    typedef struct packed {
        logic done;  // one-cycle pulse, quotients valid
        logic zero;  // both magnitudes were zero
    } t_gcd_stat;

endpackage

`default_nettype wire

// ===== rtl/rational_arith_unit.sv =====
// Top level: sequencer for signed fraction add, subtract, multiply, divide and reduce.
// Usage:
//   Input channel: i_valid / o_stall carry one request (i_op, i_a_num, i_a_den,
//   i_b_num, i_b_den). Only the low OPERAND_WIDTH bits of each operand are used,
//   sign-extended. A request is taken when i_valid is high and o_stall low.
//   Output channel: o_valid / i_stall carry one result (o_res_num, o_res_den,
//   o_status); o_status is 1 when the result denominator is zero.
//   One request is in flight at a time; o_stall is high from acceptance until
//   the result has been moved into the output register.
//   Path from acceptance to o_valid:
//     add/sub with equal denominators, unused op codes: straight to the output stage
//     add/sub/mul/div: three products through the shared multiplier, one per
//       cycle, each registered
//     reduce: binary GCD, then OPERAND_WIDTH divide steps; the binary GCD
//       loop runs one shift or subtract per cycle.
//   The result waits in the output register while i_stall is high; a finished
//   computation holds in the sequencer until the register frees up.
//   Reset (i_rst_n low, synchronous) returns to idle and drops o_valid.
`default_nettype none

module rational_arith_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::RAU_OPERAND_WIDTH
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic [rau_pkg::RAU_OP_W-1:0]         i_op,
    input  wire logic signed [rau_pkg::RAU_IN_W-1:0]  i_a_num,
    input  wire logic signed [rau_pkg::RAU_IN_W-1:0]  i_a_den,
    input  wire logic signed [rau_pkg::RAU_IN_W-1:0]  i_b_num,
    input  wire logic signed [rau_pkg::RAU_IN_W-1:0]  i_b_den,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic signed [rau_pkg::RAU_RES_W-1:0]      o_res_num,
    output logic signed [rau_pkg::RAU_RES_W-1:0]      o_res_den,
    output logic                                      o_status
);
    import rau_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int RW = RAU_RES_W;

    t_state r_state, n_state;

    t_op                r_op;
    logic signed [W-1:0] r_an, r_ad, r_bn, r_bd;
    logic [1:0]          r_step;
    logic signed [PW-1:0] r_p0, r_p1;
    logic signed [RW-1:0] r_rn, r_rd;

    logic                 r_out_valid;
    logic signed [RW-1:0] r_out_num, r_out_den;
    logic                 r_out_status;

    logic signed [W-1:0]  w_an, w_ad, w_bn, w_bd;
    t_op                  w_op;
    logic                 w_accept;
    logic                 w_load;
    logic signed [W-1:0]  w_mul_a, w_mul_b;
    logic signed [PW-1:0] w_mul_p;
    logic                 w_gcd_start;
    t_gcd_stat            w_gcd_stat;
    logic [W-1:0]         w_qn, w_qd;

    // operand fields taken from the low bits of each port
    assign w_an     = i_a_num[W-1:0];
    assign w_ad     = i_a_den[W-1:0];
    assign w_bn     = i_b_num[W-1:0];
    assign w_bd     = i_b_den[W-1:0];
    assign w_op     = t_op'(i_op);
    assign w_accept = i_valid && (r_state == S_IDLE);
    assign w_load   = (r_state == S_OUT) && (!r_out_valid || !i_stall);

    // multiplier operand select: step 0 an*bd (an*bn for mul), 1 ad*bn, 2 ad*bd
    always_comb begin
        case (r_step)
            2'd0: begin
                w_mul_a = r_an;
                w_mul_b = (r_op == OP_MUL) ? r_bn : r_bd;
            end
            2'd1: begin
                w_mul_a = r_ad;
                w_mul_b = r_bn;
            end
            default: begin
                w_mul_a = r_ad;
                w_mul_b = r_bd;
            end
        endcase
    end

    rau_mul #(
        .OPERAND_WIDTH (W)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    assign w_gcd_start = (r_state == S_RED_GO);

    rau_gcd #(
        .OPERAND_WIDTH (W)
    ) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gcd_start),
        .i_num   (r_an),
        .i_den   (r_ad),
        .o_stat  (w_gcd_stat),
        .o_qn    (w_qn),
        .o_qd    (w_qd)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (w_op) inside
                        OP_ADD, OP_SUB: n_state = (w_ad == w_bd) ? S_OUT : S_MUL;
                        OP_MUL, OP_DIV: n_state = S_MUL;
                        OP_RED:         n_state = S_RED_GO;
                        default:        n_state = S_OUT;
                    endcase
                end
            end
            S_MUL: begin
                if (r_step == 2'd3) n_state = S_OUT;
            end
            S_RED_GO:   n_state = S_RED_WAIT;
            S_RED_WAIT: begin
                if (w_gcd_stat.done) n_state = S_OUT;
            end
            S_OUT: begin
                if (w_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // operand capture and result staging
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_op   <= w_op;
                    r_an   <= w_an;
                    r_ad   <= w_ad;
                    r_bn   <= w_bn;
                    r_bd   <= w_bd;
                    r_step <= 2'd0;
                    case (w_op)
                        // equal denominators: combine numerators directly
                        OP_ADD: begin
                            r_rn <= RW'(w_an) + RW'(w_bn);
                            r_rd <= RW'(w_ad);
                        end
                        OP_SUB: begin
                            r_rn <= RW'(w_an) - RW'(w_bn);
                            r_rd <= RW'(w_ad);
                        end
                        default: begin
                            r_rn <= '0;
                            r_rd <= '0;
                        end
                    endcase
                end
            end
            S_MUL: begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd1) r_p0 <= w_mul_p;
                if (r_step == 2'd2) r_p1 <= w_mul_p;
                if (r_step == 2'd3) begin
                    // third product arrives straight from the multiplier
                    case (r_op)
                        OP_ADD: begin
                            r_rn <= RW'(r_p0) + RW'(r_p1);
                            r_rd <= RW'(w_mul_p);
                        end
                        OP_SUB: begin
                            r_rn <= RW'(r_p0) - RW'(r_p1);
                            r_rd <= RW'(w_mul_p);
                        end
                        OP_MUL: begin
                            r_rn <= RW'(r_p0);
                            r_rd <= RW'(w_mul_p);
                        end
                        OP_DIV: begin
                            r_rn <= RW'(r_p0);
                            r_rd <= RW'(r_p1);
                        end
                        default: begin
                            r_rn <= '0;
                            r_rd <= '0;
                        end
                    endcase
                end
            end
            S_RED_WAIT: begin
                if (w_gcd_stat.done) begin
                    if (w_gcd_stat.zero) begin
                        // 0/0 passes through unchanged
                        r_rn <= RW'(r_an);
                        r_rd <= RW'(r_ad);
                    end else begin
                        r_rn <= r_an[W-1] ? -RW'(w_qn) : RW'(w_qn);
                        r_rd <= r_ad[W-1] ? -RW'(w_qd) : RW'(w_qd);
                    end
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_num    <= r_rn;
            r_out_den    <= r_rd;
            r_out_status <= (r_rd == '0) ? STAT_DEN_ZERO : STAT_OK;
        end
    end

    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_res_num = r_out_num;
    assign o_res_den = r_out_den;
    assign o_status  = r_out_status;

endmodule

`default_nettype wire

// ===== rtl/rau_mul.sv =====
// Shared signed multiplier with a registered product.
`default_nettype none

module rau_mul #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic signed [OPERAND_WIDTH-1:0] i_a,
    input  wire logic signed [OPERAND_WIDTH-1:0] i_b,
    output logic signed [2*OPERAND_WIDTH-1:0]    o_p
);
    import rau_pkg::*;

    localparam int PW = 2 * OPERAND_WIDTH;

    logic signed [PW-1:0] w_a;
    logic signed [PW-1:0] w_b;
    logic signed [PW-1:0] r_p;

    // sign-extend both operands so the product is exact in PW bits
    assign w_a = PW'(i_a);
    assign w_b = PW'(i_b);

    always_ff @(posedge i_clk) begin
        r_p <= w_a * w_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== rtl/rau_gcd.sv =====
// Binary GCD followed by a two-lane restoring divide of both magnitudes by the GCD.
`default_nettype none

module rau_gcd #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic signed [OPERAND_WIDTH-1:0] i_num,
    input  wire logic signed [OPERAND_WIDTH-1:0] i_den,
    output rau_pkg::t_gcd_stat                   o_stat,
    output logic [OPERAND_WIDTH-1:0]             o_qn,
    output logic [OPERAND_WIDTH-1:0]             o_qd
);
    import rau_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W);

    t_gcd_state r_state, n_state;

    logic [W-1:0]  r_u, r_v;       // GCD working pair
    logic [CW-1:0] r_k;            // common power of two
    logic [W-1:0]  r_g;            // final GCD (divisor)
    logic [W-1:0]  r_qn, r_qd;     // dividends, become quotients
    logic [W-1:0]  r_rem_n, r_rem_d;
    logic [CW-1:0] r_cnt;
    logic          r_done, r_zero;

    logic [W-1:0] w_mag_n, w_mag_d;
    logic [W-1:0] w_sh_n, w_sh_d;
    logic         w_ge_n, w_ge_d;
    logic         w_last;

    // magnitudes; the most negative value maps to 2^(W-1), which fits
    assign w_mag_n = i_num[W-1] ? W'(-i_num) : W'(i_num);
    assign w_mag_d = i_den[W-1] ? W'(-i_den) : W'(i_den);

    // one restoring divide step per lane; remainder stays below 2^(W-1)
    assign w_sh_n = {r_rem_n[W-2:0], r_qn[W-1]};
    assign w_sh_d = {r_rem_d[W-2:0], r_qd[W-1]};
    assign w_ge_n = (w_sh_n >= r_g);
    assign w_ge_d = (w_sh_d >= r_g);
    assign w_last = (r_cnt == CW'(W - 1));

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            G_IDLE: begin
                if (i_start) n_state = G_SHIFT;
            end
            G_SHIFT: begin
                if (r_u == '0 || r_v == '0) begin
                    n_state = ((r_u | r_v) == '0) ? G_IDLE : G_DIV;
                end else if (r_u[0] || r_v[0]) begin
                    n_state = G_LOOP;
                end
            end
            G_LOOP: begin
                if (r_v == '0) n_state = G_DIV;
            end
            G_DIV: begin
                if (w_last) n_state = G_IDLE;
            end
            default: n_state = G_IDLE;
        endcase
    end

    // done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= ((r_state == G_SHIFT) && ((r_u | r_v) == '0))
                   || ((r_state == G_DIV) && w_last);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            G_IDLE: begin
                if (i_start) begin
                    r_u  <= w_mag_n;
                    r_v  <= w_mag_d;
                    r_qn <= w_mag_n;
                    r_qd <= w_mag_d;
                    r_k  <= '0;
                end
            end
            G_SHIFT: begin
                if (r_u == '0 || r_v == '0) begin
                    // gcd(x, 0) = x
                    r_g     <= r_u | r_v;
                    r_zero  <= ((r_u | r_v) == '0);
                    r_cnt   <= '0;
                    r_rem_n <= '0;
                    r_rem_d <= '0;
                end else if (!r_u[0] && !r_v[0]) begin
                    r_u <= r_u >> 1;
                    r_v <= r_v >> 1;
                    r_k <= r_k + CW'(1);
                end
            end
            G_LOOP: begin
                if (r_v == '0) begin
                    r_g     <= r_u << r_k;
                    r_zero  <= 1'b0;
                    r_cnt   <= '0;
                    r_rem_n <= '0;
                    r_rem_d <= '0;
                end else if (!r_u[0]) begin
                    r_u <= r_u >> 1;
                end else if (!r_v[0]) begin
                    r_v <= r_v >> 1;
                end else if (r_u > r_v) begin
                    // both odd: keep the smaller, replace other by the difference
                    r_u <= r_v;
                    r_v <= r_u - r_v;
                end else begin
                    r_v <= r_v - r_u;
                end
            end
            G_DIV: begin
                r_rem_n <= w_ge_n ? (w_sh_n - r_g) : w_sh_n;
                r_rem_d <= w_ge_d ? (w_sh_d - r_g) : w_sh_d;
                r_qn    <= {r_qn[W-2:0], w_ge_n};
                r_qd    <= {r_qd[W-2:0], w_ge_d};
                r_cnt   <= r_cnt + CW'(1);
            end
            default: ;
        endcase
    end

    assign o_stat = '{done: r_done, zero: r_zero};
    assign o_qn   = r_qn;
    assign o_qd   = r_qd;

endmodule

`default_nettype wire
